>>> design/tpwm_pkg.sv
package tpwm_pkg;

  localparam int CLOCK_HZ_BITS = 28;
  localparam int FREQ_BITS     = 16;
  localparam int DEAD_BITS     = 7;
  localparam int DUTY_BITS     = 16;
  localparam int COUNT_OUT_BITS = 16;
  localparam int SEL_BITS      = 2;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CLOCK_HZ_BITS-1:0] CLOCK_HZ_RESET = 28'd72000000;
  localparam logic [FREQ_BITS-1:0]     PWM_FREQ_RESET = 16'd20000;
  localparam logic [DEAD_BITS-1:0]     DEAD_RESET     = 7'd72;
  localparam logic [FREQ_BITS-1:0]     MIN_FREQ       = 16'd1200;
  localparam logic [15:0]              ADC_SPAN       = 16'd30000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef enum logic [1:0] {
    MODE_HIGH    = 2'd0,
    MODE_LOW     = 2'd1,
    MODE_DORMANT = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLOCK_HZ   = 2'd0,
    REG_PWM_FREQ   = 2'd1,
    REG_DEAD_TICKS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic  tick;
    logic  load;
    mode_t mode;
  } phase_ctl_t;

endpackage

>>> design/tpwm_period_div.sv
module tpwm_period_div #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [tpwm_pkg::CLOCK_HZ_BITS-1:0]  clock_hz,
  input  logic [tpwm_pkg::FREQ_BITS-1:0]      pwm_freq_hz,
  output logic                                busy,
  output logic [COUNTER_BITS-1:0]             period_top
);
  import tpwm_pkg::*;

  localparam int STEP_BITS = $clog2(CLOCK_HZ_BITS + 1);
  localparam int RESET_PERIOD = CLOCK_HZ_RESET / PWM_FREQ_RESET;

  logic [STEP_BITS-1:0]           step_r;
  logic [CLOCK_HZ_BITS-1:0]       quo_r;
  logic [CLOCK_HZ_BITS-1:0]       quo_nxt;
  logic [FREQ_BITS-1:0]           rem_r;
  logic [FREQ_BITS-1:0]           rem_nxt;
  logic [FREQ_BITS-1:0]           divisor_r;
  logic [FREQ_BITS:0]             trial;
  logic                           qbit;
  logic [COUNTER_BITS+CLOCK_HZ_BITS-1:0] quo_ext;
  logic [COUNTER_BITS-1:0]        period_top_r;

  always_comb begin
    trial   = {rem_r, quo_r[CLOCK_HZ_BITS-1]};
    qbit    = (trial >= {1'b0, divisor_r});
    rem_nxt = qbit ? FREQ_BITS'(trial - {1'b0, divisor_r}) : trial[FREQ_BITS-1:0];
    quo_nxt = {quo_r[CLOCK_HZ_BITS-2:0], qbit};
    quo_ext = {{COUNTER_BITS{1'b0}}, quo_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= '0;
      period_top_r <= COUNTER_BITS'(RESET_PERIOD);
    end else if (start) begin
      step_r <= STEP_BITS'(CLOCK_HZ_BITS);
    end else if (step_r != '0) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_BITS'(1)) begin
        period_top_r <= quo_ext[COUNTER_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r     <= clock_hz;
      rem_r     <= '0;
      divisor_r <= (pwm_freq_hz < MIN_FREQ) ? MIN_FREQ : pwm_freq_hz;
    end else if (step_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy       = (step_r != '0);
  assign period_top = period_top_r;

endmodule

>>> design/tpwm_phase.sv
module tpwm_phase #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tpwm_pkg::phase_ctl_t            ctl,
  input  logic [COUNTER_BITS-1:0]         compare_in,
  input  logic [COUNTER_BITS-1:0]         count,
  input  logic [tpwm_pkg::DEAD_BITS-1:0]  dead_ticks,
  output logic                            gate_high,
  output logic                            gate_low
);
  import tpwm_pkg::*;

  mode_t                   mode_r;
  logic [COUNTER_BITS-1:0] cmp_r;
  logic                    ref_prev_r;
  logic [DEAD_BITS-1:0]    dead_r;
  logic [DEAD_BITS-1:0]    dead_nxt;
  logic [DEAD_BITS-1:0]    dead_eff;
  logic                    ref_now;
  logic                    below;

  always_comb begin
    below = (count < cmp_r);
    unique case (mode_r)
      MODE_HIGH: ref_now = below;
      MODE_LOW:  ref_now = !below;
      default:   ref_now = 1'b0;
    endcase
    dead_eff  = (ref_now != ref_prev_r) ? dead_ticks : dead_r;
    gate_high = 1'b0;
    gate_low  = 1'b0;
    if (dead_eff != '0) begin
      dead_nxt = dead_eff - 1'b1;
    end else begin
      dead_nxt = '0;
      if (mode_r != MODE_DORMANT) begin
        gate_high = ref_now;
        gate_low  = !ref_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_DORMANT;
      cmp_r      <= '0;
      ref_prev_r <= 1'b0;
      dead_r     <= '0;
    end else begin
      if (ctl.load) begin
        mode_r <= ctl.mode;
        if (ctl.mode != MODE_DORMANT) begin
          cmp_r <= compare_in;
        end
      end
      if (ctl.tick) begin
        ref_prev_r <= ref_now;
        dead_r     <= dead_nxt;
      end
    end
  end

endmodule

>>> design/three_phase_pwm_dead_time.sv
// Three-phase complementary PWM generator with dead time for a motor bridge.
// Each input word is either a timer tick or a phase set command; every word
// produces exactly one result word carrying the six gate drives, the ADC
// trigger and the counter value that the word saw.
// Both channels use valid/stall. A word accepted on the input passes through
// the input register to the result register; one word per cycle is sustained
// while out_stall stays low and the divider is idle. When out_stall is high
// the result register holds and the input register fills, then in_stall rises.
// A write to clock_hz or pwm_freq_hz reruns the period divider, which retires
// one quotient bit per cycle: in_stall is high from the write until it is done.
// The user must write configuration only while no words are in flight; the block itself does not enforce it.
// After reset the period is 3600, every phase is dormant, all compare values
// are zero and the counter starts at zero; no clearing pass is needed.
module three_phase_pwm_dead_time #(
  parameter int COUNTER_BITS = 16,
  parameter int PHASE_COUNT  = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tpwm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tpwm_pkg::CLOCK_HZ_BITS-1:0]   cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [tpwm_pkg::SEL_BITS-1:0]        in_phase_sel,
  input  logic [1:0]                           in_drive_mode,
  input  logic [tpwm_pkg::DUTY_BITS-1:0]       in_duty,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_gate_high_a,
  output logic                                 out_gate_low_a,
  output logic                                 out_gate_high_b,
  output logic                                 out_gate_low_b,
  output logic                                 out_gate_high_c,
  output logic                                 out_gate_low_c,
  output logic                                 out_adc_trigger,
  output logic [tpwm_pkg::COUNT_OUT_BITS-1:0]  out_count_now
);
  import tpwm_pkg::*;

  logic [CLOCK_HZ_BITS-1:0] clock_hz_r;
  logic [FREQ_BITS-1:0]     pwm_freq_r;
  logic [DEAD_BITS-1:0]     dead_ticks_r;
  logic                     div_start_r;
  logic                     div_busy;
  logic [COUNTER_BITS-1:0]  period_top;

  logic                     s1_valid_r;
  logic                     s1_op_r;
  logic [SEL_BITS-1:0]      s1_sel_r;
  logic [1:0]               s1_mode_r;
  logic [DUTY_BITS-1:0]     s1_duty_r;
  logic                     in_take;
  logic                     advance;
  logic                     fire;
  logic                     tick_fire;
  logic                     set_fire;
  mode_t                    set_mode;

  logic [COUNTER_BITS-1:0]  count_r;
  logic [COUNTER_BITS-1:0]  count_nxt;
  logic [COUNTER_BITS-1:0]  adc_cmp_r;
  logic [COUNTER_BITS+15:0] cmp_prod;
  logic [COUNTER_BITS-1:0]  cmp_val;
  logic [31:0]              adc_prod;
  logic [COUNTER_BITS+15:0] adc_ext;
  logic [COUNTER_BITS+15:0] count_ext;
  logic                     sel_ok;

  logic [PHASE_COUNT-1:0]   hi_vec;
  logic [PHASE_COUNT-1:0]   lo_vec;
  logic [PHASE_COUNT+2:0]   hi_pad;
  logic [PHASE_COUNT+2:0]   lo_pad;

  logic                     out_valid_r;
  logic [5:0]               out_gates_r;
  logic                     out_adc_r;
  logic [COUNT_OUT_BITS-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r   <= CLOCK_HZ_RESET;
      pwm_freq_r   <= PWM_FREQ_RESET;
      dead_ticks_r <= DEAD_RESET;
      div_start_r  <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CLOCK_HZ: begin
            clock_hz_r  <= cfg_wdata;
            div_start_r <= 1'b1;
          end
          REG_PWM_FREQ: begin
            pwm_freq_r  <= cfg_wdata[FREQ_BITS-1:0];
            div_start_r <= 1'b1;
          end
          REG_DEAD_TICKS: dead_ticks_r <= cfg_wdata[DEAD_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  tpwm_period_div #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start_r),
    .clock_hz   (clock_hz_r),
    .pwm_freq_hz(pwm_freq_r),
    .busy       (div_busy),
    .period_top (period_top)
  );

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = div_start_r || div_busy || (s1_valid_r && !advance);
  assign in_take   = in_valid && !in_stall;
  assign fire      = s1_valid_r && advance;
  assign tick_fire = fire && (s1_op_r == OP_TICK);
  assign set_fire  = fire && (s1_op_r == OP_SET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_op;
      s1_sel_r  <= in_phase_sel;
      s1_mode_r <= in_drive_mode;
      s1_duty_r <= in_duty;
    end
  end

  always_comb begin
    unique case (s1_mode_r)
      MODE_HIGH: set_mode = MODE_HIGH;
      MODE_LOW:  set_mode = MODE_LOW;
      default:   set_mode = MODE_DORMANT;
    endcase
    sel_ok    = (32'(s1_sel_r) < PHASE_COUNT);
    cmp_prod  = {{COUNTER_BITS{1'b0}}, s1_duty_r} *
                {16'b0, period_top};
    cmp_val   = cmp_prod[COUNTER_BITS+15:16];
    adc_prod  = {16'b0, s1_duty_r} * {16'b0, ADC_SPAN};
    adc_ext   = {{COUNTER_BITS{1'b0}}, adc_prod[31:16]};
    count_ext = {16'b0, count_r};
    count_nxt = (count_r == period_top) ? '0 : count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      adc_cmp_r <= '0;
    end else begin
      if (tick_fire) begin
        count_r <= count_nxt;
      end
      if (set_fire && sel_ok && set_mode != MODE_DORMANT) begin
        adc_cmp_r <= adc_ext[COUNTER_BITS-1:0];
      end
    end
  end

  for (genvar p = 0; p < PHASE_COUNT; p++) begin : g_phase
    phase_ctl_t ctl;
    always_comb begin
      ctl.tick = tick_fire;
      ctl.load = set_fire && (32'(s1_sel_r) == p);
      ctl.mode = set_mode;
    end
    tpwm_phase #(
      .COUNTER_BITS(COUNTER_BITS)
    ) u_phase (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .compare_in(cmp_val),
      .count     (count_r),
      .dead_ticks(dead_ticks_r),
      .gate_high (hi_vec[p]),
      .gate_low  (lo_vec[p])
    );
  end

  assign hi_pad = {3'b000, hi_vec};
  assign lo_pad = {3'b000, lo_vec};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_count_r <= count_ext[COUNT_OUT_BITS-1:0];
      if (s1_op_r == OP_TICK) begin
        out_gates_r <= {lo_pad[2], hi_pad[2], lo_pad[1], hi_pad[1], lo_pad[0], hi_pad[0]};
        out_adc_r   <= (count_r == adc_cmp_r);
      end else begin
        out_gates_r <= '0;
        out_adc_r   <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_gate_high_a = out_gates_r[0];
  assign out_gate_low_a  = out_gates_r[1];
  assign out_gate_high_b = out_gates_r[2];
  assign out_gate_low_b  = out_gates_r[3];
  assign out_gate_high_c = out_gates_r[4];
  assign out_gate_low_c  = out_gates_r[5];
  assign out_adc_trigger = out_adc_r;
  assign out_count_now   = out_count_r;

  a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_gates_r[0] && out_gates_r[1]) &&
                    !(out_gates_r[2] && out_gates_r[3]) &&
                    !(out_gates_r[4] && out_gates_r[5]))
    else $error("high and low gate of one phase both on");

  a_set_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    set_fire |=> $stable(count_r))
    else $error("counter moved on a set word");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |=> div_busy)
    else $error("period divider did not start");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && out_valid_r)
    else $error("word dropped while output stalled");

endmodule

>>> dv/pwm_bridge_checker.sv
`timescale 1ns / 100ps

module pwm_bridge_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tpwm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [tpwm_pkg::CLOCK_HZ_BITS-1:0]  cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_op,
  input  logic [tpwm_pkg::SEL_BITS-1:0]       in_phase_sel,
  input  logic [1:0]                          in_drive_mode,
  input  logic [tpwm_pkg::DUTY_BITS-1:0]      in_duty,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_gate_high_a,
  input  logic                                out_gate_low_a,
  input  logic                                out_gate_high_b,
  input  logic                                out_gate_low_b,
  input  logic                                out_gate_high_c,
  input  logic                                out_gate_low_c,
  input  logic                                out_adc_trigger,
  input  logic [tpwm_pkg::COUNT_OUT_BITS-1:0] out_count_now,
  output int                                  pending_words,
  output int                                  mismatches
);
  import tpwm_pkg::*;

  localparam int PHASES = 3;

  typedef struct packed {
    logic        gate_high_a;
    logic        gate_low_a;
    logic        gate_high_b;
    logic        gate_low_b;
    logic        gate_high_c;
    logic        gate_low_c;
    logic        adc_trigger;
    logic [15:0] count_now;
  } gate_word_t;

  logic [CLOCK_HZ_BITS-1:0] clk_hz;
  logic [FREQ_BITS-1:0]     freq_hz;
  logic [DEAD_BITS-1:0]     dead_len;
  logic [15:0]              count;
  logic [15:0]              top;
  logic [15:0]              adc_cmp;
  mode_t                    mode [PHASES];
  logic [15:0]              cmp [PHASES];
  logic                     level_last [PHASES];
  logic [DEAD_BITS-1:0]     dead_left [PHASES];
  gate_word_t               words_due [$];
  int                       errs = 0;

  function automatic logic [15:0] period_for(logic [CLOCK_HZ_BITS-1:0] hz,
                                             logic [FREQ_BITS-1:0] f);
    logic [FREQ_BITS-1:0] div;
    div = (f < MIN_FREQ) ? MIN_FREQ : f;
    return 16'(hz / div);
  endfunction

  task automatic restore_reset();
    clk_hz = CLOCK_HZ_RESET;
    freq_hz = PWM_FREQ_RESET;
    dead_len = DEAD_RESET;
    top = period_for(clk_hz, freq_hz);
    count = '0;
    adc_cmp = '0;
    for (int p = 0; p < PHASES; p++) begin
      mode[p] = MODE_DORMANT;
      cmp[p] = '0;
      level_last[p] = 1'b0;
      dead_left[p] = '0;
    end
  endtask

  task automatic step_bridge(input logic op, input logic [1:0] sel, input logic [1:0] dm,
                             input logic [15:0] duty, output gate_word_t w);
    logic [PHASES-1:0] hi;
    logic [PHASES-1:0] lo;
    logic              level;
    w = '0;
    hi = '0;
    lo = '0;
    w.count_now = count;
    if (op == OP_SET) begin
      if (sel < PHASES) begin
        if (dm == MODE_HIGH || dm == MODE_LOW) begin
          mode[sel] = mode_t'(dm);
          cmp[sel] = 16'((32'(duty) * 32'(top)) >> 16);
          adc_cmp = 16'((32'(duty) * 32'(ADC_SPAN)) >> 16);
        end else begin
          mode[sel] = MODE_DORMANT;
        end
      end
    end else begin
      for (int p = 0; p < PHASES; p++) begin
        level = 1'b0;
        if (mode[p] == MODE_HIGH) begin
          level = (count < cmp[p]);
        end else if (mode[p] == MODE_LOW) begin
          level = !(count < cmp[p]);
        end
        if (level != level_last[p]) begin
          dead_left[p] = dead_len;
        end
        level_last[p] = level;
        if (dead_left[p] != 0) begin
          dead_left[p] = dead_left[p] - 1'b1;
        end else if (mode[p] != MODE_DORMANT) begin
          hi[p] = level;
          lo[p] = !level;
        end
      end
      w.gate_high_a = hi[0];
      w.gate_low_a = lo[0];
      w.gate_high_b = hi[1];
      w.gate_low_b = lo[1];
      w.gate_high_c = hi[2];
      w.gate_low_c = lo[2];
      w.adc_trigger = (count == adc_cmp);
      count = (count == top) ? 16'd0 : count + 16'd1;
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    gate_word_t want;
    gate_word_t got;
    gate_word_t next_due;
    if (!rst_n) begin
      restore_reset();
      words_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLOCK_HZ: begin
            clk_hz = cfg_wdata;
            top = period_for(clk_hz, freq_hz);
          end
          REG_PWM_FREQ: begin
            freq_hz = cfg_wdata[FREQ_BITS-1:0];
            top = period_for(clk_hz, freq_hz);
          end
          REG_DEAD_TICKS: begin
            dead_len = cfg_wdata[DEAD_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        got.gate_high_a = out_gate_high_a;
        got.gate_low_a = out_gate_low_a;
        got.gate_high_b = out_gate_high_b;
        got.gate_low_b = out_gate_low_b;
        got.gate_high_c = out_gate_high_c;
        got.gate_low_c = out_gate_low_c;
        got.adc_trigger = out_adc_trigger;
        got.count_now = out_count_now;
        if (words_due.size() == 0) begin
          $error("result word arrived with no word expected");
          errs++;
        end else begin
          want = words_due.pop_front();
          check_field("gate_high_a", want.gate_high_a, got.gate_high_a);
          check_field("gate_low_a", want.gate_low_a, got.gate_low_a);
          check_field("gate_high_b", want.gate_high_b, got.gate_high_b);
          check_field("gate_low_b", want.gate_low_b, got.gate_low_b);
          check_field("gate_high_c", want.gate_high_c, got.gate_high_c);
          check_field("gate_low_c", want.gate_low_c, got.gate_low_c);
          check_field("adc_trigger", want.adc_trigger, got.adc_trigger);
          check_field("count_now", want.count_now, got.count_now);
        end
      end
      if (in_valid && !in_stall) begin
        step_bridge(in_op, in_phase_sel, in_drive_mode, in_duty, next_due);
        words_due.push_back(next_due);
      end
    end
    pending_words <= words_due.size();
    mismatches <= errs;
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tpwm_pkg::*;

  localparam logic [1:0] PHASE_A       = 2'd0;
  localparam logic [1:0] PHASE_B       = 2'd1;
  localparam logic [1:0] PHASE_C       = 2'd2;
  localparam logic [1:0] PHASE_NONE    = 2'd3;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CLOCK_HZ_BITS-1:0]  cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_op = OP_TICK;
  logic [SEL_BITS-1:0]       in_phase_sel = '0;
  logic [1:0]                in_drive_mode = '0;
  logic [DUTY_BITS-1:0]      in_duty = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_gate_high_a;
  logic                      out_gate_low_a;
  logic                      out_gate_high_b;
  logic                      out_gate_low_b;
  logic                      out_gate_high_c;
  logic                      out_gate_low_c;
  logic                      out_adc_trigger;
  logic [COUNT_OUT_BITS-1:0] out_count_now;
  int                        pending_words;
  int                        mismatches;
  logic                      quiet = 1'b0;
  int                        gap_odds = 0;
  int                        stall_left = 0;
  int                        run_left = 0;

  always #5 clk = ~clk;

  three_phase_pwm_dead_time uut (.*);

  pwm_bridge_checker bridge_check (.*);

  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
      run_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (run_left > 0) begin
      run_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 1) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
      run_left = $urandom_range(0, 30);
    end
  end

  task automatic send_word(input logic op, input logic [1:0] sel, input logic [1:0] dm,
                           input logic [15:0] duty);
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_op <= op;
    in_phase_sel <= sel;
    in_drive_mode <= dm;
    in_duty <= duty;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CLOCK_HZ_BITS-1:0] val);
    in_valid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input logic [CLOCK_HZ_BITS-1:0] hz, input logic [15:0] freq,
                            input logic [6:0] dead);
    write_reg(REG_CLOCK_HZ, hz);
    write_reg(REG_PWM_FREQ, 28'(freq));
    write_reg(REG_DEAD_TICKS, 28'(dead));
    gap_odds = $urandom_range(0, 2) * 4;
  endtask

  task automatic random_words(input int n);
    logic        op;
    logic [1:0]  sel;
    logic [15:0] duty;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < 12) ? OP_SET : OP_TICK;
      sel = ($urandom_range(0, 9) == 0) ? PHASE_NONE : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 7))
        0: duty = 16'h0000;
        1: duty = 16'hFFFF;
        default: duty = 16'($urandom);
      endcase
      send_word(op, sel, 2'($urandom), duty);
    end
  endtask

  initial begin
    logic [15:0] freq;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_odds = 4;
    send_word(OP_TICK, PHASE_A, MODE_HIGH, 16'h0000);
    send_word(OP_SET, PHASE_A, MODE_HIGH, 16'hFFFF);
    send_word(OP_SET, PHASE_B, MODE_LOW, 16'h0000);
    send_word(OP_SET, PHASE_C, MODE_HIGH, 16'h8000);
    send_word(OP_SET, PHASE_NONE, MODE_HIGH, 16'h1234);
    send_word(OP_SET, PHASE_C, MODE_RESERVED, 16'hFFFF);
    send_word(OP_TICK, PHASE_NONE, MODE_RESERVED, 16'hFFFF);
    send_word(OP_SET, PHASE_C, MODE_DORMANT, 16'hFFFF);
    send_word(OP_SET, PHASE_C, MODE_HIGH, 16'h0001);
    repeat (10) send_word(OP_TICK, PHASE_A, MODE_LOW, 16'h5A5A);
    send_word(OP_SET, PHASE_A, MODE_LOW, 16'hAAAA);
    send_word(OP_TICK, PHASE_B, MODE_HIGH, 16'h0000);
    send_word(OP_SET, PHASE_B, MODE_HIGH, 16'h5555);
    repeat (3) send_word(OP_TICK, PHASE_C, MODE_DORMANT, 16'hFFFF);

    // Stopping the clock with the counter above zero leaves the counter above
    // the period, so it keeps counting up past it.
    quiet <= 1'b1;
    send_word(OP_SET, PHASE_A, MODE_HIGH, 16'h8000);
    send_word(OP_SET, PHASE_B, MODE_LOW, 16'h4000);
    send_word(OP_SET, PHASE_C, MODE_HIGH, 16'hC000);
    write_reg(REG_CLOCK_HZ, 28'd0);
    repeat (150) send_word(OP_TICK, PHASE_A, MODE_HIGH, 16'h0000);
    quiet <= 1'b0;

    set_timing(28'd1, 16'd0, 7'd0);
    random_words(30);
    set_timing(28'd50000, 16'd1000, 7'd3);
    random_words(400);
    set_timing(28'd300000, 16'd1200, 7'd0);
    random_words(450);
    set_timing(28'hFFFFFFF, 16'd4000, 7'd127);
    random_words(300);
    set_timing(28'd200000000, 16'hFFFF, 7'($urandom));
    random_words(250);

    freq = 16'($urandom_range(1200, 65535));
    set_timing(28'(freq * $urandom_range(3100, 4000) + $urandom_range(0, freq - 1)),
               freq, 7'($urandom));
    quiet <= 1'b1;
    random_words(150);

    in_valid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_words == 0) begin
      $display("three_phase_pwm_dead_time regression: pass");
    end else begin
      $display("three_phase_pwm_dead_time regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("three_phase_pwm_dead_time regression: fail");
    $finish;
  end

endmodule

>>> three_phase_pwm_dead_time.f
design/tpwm_pkg.sv
design/tpwm_period_div.sv
design/tpwm_phase.sv
design/three_phase_pwm_dead_time.sv
dv/pwm_bridge_checker.sv
dv/testbench.sv
